FILE: design/keyword_token_prefix_counter_unit_defines.svh
// Assertion macros used by the port-level checker file.
`ifndef KEYWORD_TOKEN_PREFIX_COUNTER_UNIT_DEFINES_SVH
`define KEYWORD_TOKEN_PREFIX_COUNTER_UNIT_DEFINES_SVH

// Assert that an antecedent implies a consequent on the next cycle.
`define KTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle.
`define KTPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/ktpc_pkg.sv
// Package with opcodes, widths, delimiter and folding helpers.
package ktpc_pkg;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 5;
    localparam int POS_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 32;
    localparam int CFG_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_TEXT = 2'd1,
        OP_PAGE = 2'd2,
        OP_READ = 2'd3
    } opcode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a keyword byte
        logic text;     // shift a text byte and start the compare sweep
        logic restart;  // clear history and marks
        logic step;     // compare one keyword and update its total
        logic read;     // register a total for output
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_kw;  // sweep index reached the final active keyword
        logic none;     // no active keyword
    } ctrl_stat_t;

    function automatic logic is_delim(input logic [BYTE_W-1:0] c);
        logic r;
        r = 1'b0;
        case (c)
            8'h2E, 8'h2C, 8'h2D, 8'h22, 8'h27, 8'h3B, 8'h3A, 8'h3F, 8'h21,
            8'h40, 8'h23, 8'h2F, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h5B, 8'h5D,
            8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h5C, 8'h5F, 8'h7E, 8'h2B, 8'h3D,
            8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0C, 8'h0B: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
            r = c + 8'd32;
        return r;
    endfunction

endpackage

FILE: design/ktpc_datapath.sv
// Datapath: keyword store, text history, per-keyword compare and totals.
module ktpc_datapath #(
    parameter int MAX_KEYWORDS    = 32,
    parameter int MAX_KEYWORD_LEN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ktpc_pkg::ctrl_cmd_t           cmd,
    output ktpc_pkg::ctrl_stat_t          stat,
    input  logic [ktpc_pkg::CFG_W-1:0]    active_keywords,
    input  logic [ktpc_pkg::SLOT_W-1:0]   keyword_slot,
    input  logic [ktpc_pkg::POS_W-1:0]    char_position,
    input  logic [ktpc_pkg::BYTE_W-1:0]   data_byte,
    output logic [ktpc_pkg::SLOT_W-1:0]   total_slot,
    output logic [ktpc_pkg::TOTAL_W-1:0]  hit_total
);
    localparam int KW_W  = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;
    localparam int LEN_W = $clog2(MAX_KEYWORD_LEN + 1);
    localparam int IDX_W = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
    localparam int BW    = ktpc_pkg::BYTE_W;
    localparam int WORD_W = MAX_KEYWORD_LEN * BW;

    // One word per keyword; bytes sit at position * BW.
    logic [WORD_W-1:0] kw_mem [MAX_KEYWORDS];
    logic [WORD_W-1:0] kw_word_reg;
    logic [LEN_W-1:0] len_reg [MAX_KEYWORDS];
    logic [ktpc_pkg::TOTAL_W-1:0] tot_reg [MAX_KEYWORDS];
    logic [BW-1:0]    hist_reg [MAX_KEYWORD_LEN];
    logic [MAX_KEYWORD_LEN-1:0] mark_reg;
    logic             prev_delim_reg;
    logic [KW_W-1:0]  idx_reg;
    logic [ktpc_pkg::CFG_W:0] count;

    logic slot_ok, pos_ok, is_d, hit;
    logic [LEN_W-1:0] cur_len;

    assign slot_ok = 32'(keyword_slot) < 32'(MAX_KEYWORDS);
    assign pos_ok  = 32'(char_position) < 32'(MAX_KEYWORD_LEN);
    assign is_d    = ktpc_pkg::is_delim(data_byte);

    // Clamp the active count to the number of keyword slots.
    assign count = (32'(active_keywords) > 32'(MAX_KEYWORDS))
                   ? (ktpc_pkg::CFG_W+1)'(MAX_KEYWORDS)
                   : {1'b0, active_keywords};
    assign stat.none    = (count == '0);
    assign stat.last_kw = (32'(idx_reg) + 32'd1 >= 32'(count));

    assign cur_len = len_reg[idx_reg];

    // Compare keyword idx_reg (word held in kw_word_reg) against the history window.
    always_comb
    begin
        logic ok;
        ok = 1'b1;
        if (cur_len == '0)
        begin
            hit = mark_reg[0];
        end
        else
        begin
            hit = mark_reg[IDX_W'(cur_len - LEN_W'(1))];
            for (int j = 0; j < MAX_KEYWORD_LEN; j++)
            begin
                if (32'(j) < 32'(cur_len) &&
                    hist_reg[IDX_W'(32'(cur_len) - 32'd1 - 32'(j))] !=
                    ktpc_pkg::fold(kw_word_reg[BW*j +: BW]))
                    ok = 1'b0;
            end
            hit = hit & ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && slot_ok && pos_ok && data_byte != '0)
            kw_mem[KW_W'(keyword_slot)][BW*32'(char_position) +: BW] <= data_byte;
        // Fetch the word of the keyword compared in the next cycle.
        if (cmd.text)
            kw_word_reg <= kw_mem[0];
        else if (cmd.step)
            kw_word_reg <= kw_mem[idx_reg + KW_W'(1)];
        if (cmd.read)
        begin
            total_slot <= keyword_slot;
            hit_total  <= slot_ok ? tot_reg[KW_W'(keyword_slot)] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_KEYWORDS; i++)
            begin
                len_reg[i] <= '0;
                tot_reg[i] <= '0;
            end
            for (int k = 0; k < MAX_KEYWORD_LEN; k++)
                hist_reg[k] <= '0;
            mark_reg       <= '0;
            prev_delim_reg <= 1'b1;
            idx_reg        <= '0;
        end
        else
        begin
            if (cmd.load && slot_ok && pos_ok)
                len_reg[KW_W'(keyword_slot)] <= (data_byte == '0)
                    ? LEN_W'(char_position) : LEN_W'(char_position) + LEN_W'(1);
            if (cmd.restart)
            begin
                for (int k = 0; k < MAX_KEYWORD_LEN; k++)
                    hist_reg[k] <= '0;
                mark_reg       <= '0;
                prev_delim_reg <= 1'b1;
            end
            else if (cmd.text)
            begin
                for (int k = MAX_KEYWORD_LEN - 1; k > 0; k--)
                    hist_reg[k] <= hist_reg[k-1];
                hist_reg[0]    <= ktpc_pkg::fold(data_byte);
                mark_reg       <= {mark_reg[MAX_KEYWORD_LEN-2:0], !is_d && prev_delim_reg};
                prev_delim_reg <= is_d;
            end
            if (cmd.text)
                idx_reg <= '0;
            else if (cmd.step)
            begin
                if (hit && tot_reg[idx_reg] != '1)
                    tot_reg[idx_reg] <= tot_reg[idx_reg] + 32'd1;
                idx_reg <= idx_reg + KW_W'(1);
            end
        end
    end
endmodule

FILE: design/ktpc_ctrl.sv
// Controller: handshakes, opcode decode and keyword sweep sequencing.
module ktpc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ktpc_pkg::OP_W-1:0]    opcode,
    input  logic [ktpc_pkg::BYTE_W-1:0]  data_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ktpc_pkg::ctrl_cmd_t          cmd,
    input  ktpc_pkg::ctrl_stat_t         stat
);
    typedef enum logic [0:0] {ST_IDLE, ST_SWEEP} state_t;
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   acc;
    ktpc_pkg::opcode_t op;

    assign op        = ktpc_pkg::opcode_t'(opcode);
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign acc       = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (op)
                        ktpc_pkg::OP_LOAD: cmd.load = 1'b1;
                        ktpc_pkg::OP_TEXT:
                        begin
                            if (data_byte == '0)
                                cmd.restart = 1'b1;
                            else
                            begin
                                cmd.text = 1'b1;
                                if (!stat.none)
                                    state_next = ST_SWEEP;
                            end
                        end
                        ktpc_pkg::OP_PAGE: cmd.restart = 1'b1;
                        ktpc_pkg::OP_READ:
                        begin
                            cmd.read = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        default: cmd = '0;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                cmd.step = 1'b1;
                if (stat.last_kw)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

FILE: design/keyword_token_prefix_counter_unit.sv
// A read total is registered and appears in the cycle after its transfer.
// Load, page and read items need no sweep; a nonzero text byte, when a keyword
// is active, starts a sweep in which one shared compare unit takes the active
// keywords one per cycle, and no new item is taken until the sweep ends.
// Reset: totals, lengths, history, marks and the register clear at once.
module keyword_token_prefix_counter_unit #(
    parameter int MAX_KEYWORDS    = 32,
    parameter int MAX_KEYWORD_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [4:0]  keyword_slot,
    input  logic [3:0]  char_position,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  total_slot,
    output logic [31:0] hit_total
);
    logic [ktpc_pkg::CFG_W-1:0] active_reg;
    ktpc_pkg::ctrl_cmd_t  cmd;
    ktpc_pkg::ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '0;
        else if (cfg_valid)
            active_reg <= cfg_data;
    end

    ktpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .data_byte(data_byte), .out_valid(out_valid),
        .out_ready(out_ready), .cmd(cmd), .stat(stat)
    );

    ktpc_datapath #(
        .MAX_KEYWORDS(MAX_KEYWORDS), .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .active_keywords(active_reg), .keyword_slot(keyword_slot),
        .char_position(char_position), .data_byte(data_byte),
        .total_slot(total_slot), .hit_total(hit_total)
    );
endmodule

FILE: design/ktpc_checker.sv
// Port-level checker for the keyword counter, bound to the top level.
`include "keyword_token_prefix_counter_unit_defines.svh"
module ktpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  opcode,
    input logic [4:0]  keyword_slot,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  total_slot
);
    `KTPC_ASSERT_NEXT(a_read_gives_out, clk, rst_n, in_valid && in_ready && opcode == ktpc_pkg::OP_READ, out_valid, "read transfer gave no result")
    `KTPC_ASSERT_NEXT(a_read_slot, clk, rst_n, in_valid && in_ready && opcode == ktpc_pkg::OP_READ, total_slot == $past(keyword_slot), "result slot differs from read slot")
    `KTPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(total_slot), "stalled result changed")
    `KTPC_ASSERT_NEXT(a_no_spurious, clk, rst_n, !out_valid && !(in_valid && in_ready && opcode == ktpc_pkg::OP_READ), !out_valid, "result without read")
endmodule

bind keyword_token_prefix_counter_unit ktpc_checker u_ktpc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .keyword_slot(keyword_slot), .out_valid(out_valid),
    .out_ready(out_ready), .total_slot(total_slot)
);
